// ===== rtl/bgjc_pkg.sv =====
// Shared types and codes of the block Gauss-Jordan conditioner.
package bgjc_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] ST_READ = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	typedef enum logic [2:0] {WS_IN, WS_DIV, WS_SUB, WS_ONE, WS_ZERO} wsel_t;
	typedef enum logic [2:0] {LD_NONE, LD_P, LD_X, LD_A, LD_B} ld_t;

	typedef struct packed {
		logic       mem_we;
		logic       mem_re;
		wsel_t      wsel;
		ld_t        ld;
		logic       div_start;
		logic       mul_go;
		logic       rnd_go;
		logic       sub_go;
		logic       out_load;
		logic       out_zero;
		logic [1:0] out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic p_zero;
		logic x_zero;
		logic div_done;
	} dp_stat_t;

endpackage

// ===== rtl/bgjc_qdiv.sv =====
// Iterative Q16.16 divider, one quotient bit per cycle, rounded and saturated.
module bgjc_qdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	logic        busy_q, fin_q, done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] pa_q, rem_q;
	logic [47:0] n_q;
	logic [31:0] quo_q;

	logic [31:0] num_mag, den_mag;
	logic [32:0] t;
	logic        ge;
	logic        rnd;
	logic [48:0] qr;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_mag = den[31] ? (~den + 32'd1) : den;
	assign t       = {rem_q, n_q[47]};
	assign ge      = t >= {1'b0, pa_q};
	assign rnd     = {rem_q, 1'b0} >= {1'b0, pa_q};
	assign qr      = {1'b0, n_q} + {48'd0, rnd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31] ^ den[31];
			pa_q  <= den_mag;
			n_q   <= {num_mag, 16'd0};
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(t - {1'b0, pa_q}) : t[31:0];
			n_q   <= {n_q[46:0], ge};
		end
		if (fin_q) begin
			if (neg_q) begin
				quo_q <= (qr >= 49'h0_8000_0000) ? 32'h8000_0000 : 32'(~qr + 49'd1);
			end else begin
				quo_q <= (qr > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/bgjc_datapath.sv =====
// Datapath: entry store, operand registers, divider, multiply-subtract and result register.
module bgjc_datapath #(
	parameter int RW = 3,
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bgjc_pkg::dp_cmd_t   cmd,
	input  logic [RW-1:0]       mem_row,
	input  logic [CW-1:0]       mem_col,
	input  logic signed [31:0]  entry_value,
	output bgjc_pkg::dp_stat_t  stat,
	output logic signed [31:0]  read_value,
	output logic [1:0]          status
);

	localparam int DEPTH = 2 ** (RW + CW);

	logic signed [31:0] mem [0:DEPTH-1];
	logic signed [31:0] rdata_q;
	logic signed [31:0] p_q, x_q, a_q, b_q;
	logic signed [63:0] prod_s1;
	logic signed [47:0] m_s2;
	logic signed [31:0] res_q;
	logic signed [31:0] read_value_q;
	logic [1:0]         status_q;

	logic signed [31:0] wdata;
	logic signed [31:0] div_quo;
	logic               div_done;
	logic signed [63:0] rsum;
	logic signed [49:0] diff;

	bgjc_qdiv u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (a_q),
		.den   (p_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		unique case (cmd.wsel)
			bgjc_pkg::WS_IN:   wdata = entry_value;
			bgjc_pkg::WS_DIV:  wdata = div_quo;
			bgjc_pkg::WS_SUB:  wdata = res_q;
			bgjc_pkg::WS_ONE:  wdata = bgjc_pkg::Q_ONE;
			bgjc_pkg::WS_ZERO: wdata = '0;
			default:           wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[{mem_row, mem_col}] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[{mem_row, mem_col}];
		end
	end

	// Rounding half away from zero: negative products take a bias one short of a half.
	assign rsum = prod_s1 + (prod_s1[63] ? 64'sd32767 : 64'sd32768);
	assign diff = 50'(b_q) - 50'(m_s2);

	always_ff @(posedge clk) begin
		unique case (cmd.ld)
			bgjc_pkg::LD_P:    p_q <= rdata_q;
			bgjc_pkg::LD_X:    x_q <= rdata_q;
			bgjc_pkg::LD_A:    a_q <= rdata_q;
			bgjc_pkg::LD_B:    b_q <= rdata_q;
			bgjc_pkg::LD_NONE: ;
			default:           ;
		endcase
		if (cmd.mul_go) begin
			prod_s1 <= x_q * a_q;
		end
		if (cmd.rnd_go) begin
			m_s2 <= rsum[63:16];
		end
		if (cmd.sub_go) begin
			if (diff > 50'sh0_7FFF_FFFF) begin
				res_q <= 32'sh7FFF_FFFF;
			end else if (diff < -50'sh0_8000_0000) begin
				res_q <= 32'sh8000_0000;
			end else begin
				res_q <= diff[31:0];
			end
		end
		if (cmd.out_load) begin
			read_value_q <= cmd.out_zero ? 32'sd0 : rdata_q;
			status_q     <= cmd.out_status;
		end
	end

	assign stat.p_zero   = (p_q == 32'sd0);
	assign stat.x_zero   = (x_q == 32'sd0);
	assign stat.div_done = div_done;
	assign read_value    = read_value_q;
	assign status        = status_q;

endmodule

// ===== rtl/bgjc_ctrl.sv =====
// Controller: input handshake, held marks, elimination sequencer and output valid.
module bgjc_ctrl #(
	parameter int LOCAL_ROWS = 8,
	parameter int COLUMNS    = 16,
	parameter int RW         = 3,
	parameter int CW         = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         row_index,
	input  logic [4:0]         column_index,
	input  logic               hold_row,
	input  logic [3:0]         cfg_rows,
	input  logic [4:0]         cfg_cols,
	output logic               out_valid,
	input  logic               out_stall,
	output bgjc_pkg::dp_cmd_t  cmd,
	output logic [RW-1:0]      mem_row,
	output logic [CW-1:0]      mem_col,
	input  bgjc_pkg::dp_stat_t stat
);

	localparam int JW = $clog2(LOCAL_ROWS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_RD_WAIT, S_J_CHECK, S_P_LOAD, S_P_TEST, S_N_RD, S_N_LDA, S_N_DST,
		S_N_DIV, S_N_NEXT, S_K_CHECK, S_X_LOAD, S_X_TEST, S_C_RDA, S_C_LDA, S_C_LDB,
		S_C_MUL, S_C_RND, S_C_WR, S_C_NEXT, S_FINISH
	} state_t;

	state_t              state_q;
	logic [JW-1:0]       j_q, k_q;
	logic [CW-1:0]       l_q;
	logic                zero_q;
	logic                rd_ok_q;
	logic                out_valid_q;
	logic [LOCAL_ROWS-1:0] held_q;

	logic          accept, ok, out_busy;
	logic [31:0]   nc32, nr32;
	logic [JW-1:0] nr;
	logic          jlt, klt, l_is_j, l_last;
	logic [CW-1:0] l_next;
	logic [RW-1:0] j_row, k_row, in_row;
	logic [CW-1:0] j_col;

	assign out_busy = out_valid_q && out_stall;
	assign in_stall = (state_q != S_IDLE) || out_busy;
	assign accept   = in_valid && !in_stall;
	assign ok       = (32'(row_index) < LOCAL_ROWS) && (32'(column_index) <= COLUMNS);

	// Effective counts: columns clipped to the store, rows clipped to store and columns.
	always_comb begin
		nc32 = (32'(cfg_cols) > COLUMNS) ? COLUMNS : 32'(cfg_cols);
		nr32 = (32'(cfg_rows) > LOCAL_ROWS) ? LOCAL_ROWS : 32'(cfg_rows);
		if (nr32 > nc32) begin
			nr32 = nc32;
		end
	end

	assign nr     = JW'(nr32);
	assign jlt    = j_q < nr;
	assign klt    = k_q < nr;
	assign l_is_j = 32'(l_q) == 32'(j_q);
	assign l_last = 32'(l_q) == COLUMNS;
	// After the last used column the walk jumps to the right-hand side.
	assign l_next = (32'(l_q) + 32'd1 == nc32) ? CW'(COLUMNS) : CW'(32'(l_q) + 32'd1);
	assign j_row  = RW'(j_q);
	assign k_row  = RW'(k_q);
	assign j_col  = CW'(j_q);
	assign in_row = RW'(row_index);

	always_comb begin
		cmd     = '0;
		mem_row = in_row;
		mem_col = CW'(column_index);
		unique case (state_q)
			S_IDLE: begin
				if (accept && ok) begin
					cmd.mem_we = (mode == bgjc_pkg::MODE_WRITE);
					cmd.mem_re = (mode == bgjc_pkg::MODE_READ);
				end
			end
			S_RD_WAIT: begin
				cmd.out_load   = !out_busy;
				cmd.out_zero   = !rd_ok_q;
				cmd.out_status = bgjc_pkg::ST_READ;
			end
			S_J_CHECK: begin
				mem_row    = j_row;
				mem_col    = j_col;
				cmd.mem_re = jlt && !held_q[j_row];
			end
			S_P_LOAD: cmd.ld = bgjc_pkg::LD_P;
			S_P_TEST: ;
			S_N_RD: begin
				mem_row = j_row;
				mem_col = l_q;
				if (l_is_j) begin
					cmd.mem_we = 1'b1;
					cmd.wsel   = bgjc_pkg::WS_ONE;
				end else begin
					cmd.mem_re = 1'b1;
				end
			end
			S_N_LDA: cmd.ld = bgjc_pkg::LD_A;
			S_N_DST: cmd.div_start = 1'b1;
			S_N_DIV: begin
				mem_row    = j_row;
				mem_col    = l_q;
				cmd.mem_we = stat.div_done;
				cmd.wsel   = bgjc_pkg::WS_DIV;
			end
			S_N_NEXT: ;
			S_K_CHECK: begin
				mem_row    = k_row;
				mem_col    = j_col;
				cmd.mem_re = klt && (k_q != j_q);
			end
			S_X_LOAD: cmd.ld = bgjc_pkg::LD_X;
			S_X_TEST: ;
			S_C_RDA: begin
				mem_col = l_q;
				if (l_is_j) begin
					mem_row    = k_row;
					cmd.mem_we = 1'b1;
					cmd.wsel   = bgjc_pkg::WS_ZERO;
				end else begin
					mem_row    = j_row;
					cmd.mem_re = 1'b1;
				end
			end
			S_C_LDA: begin
				cmd.ld     = bgjc_pkg::LD_A;
				mem_row    = k_row;
				mem_col    = l_q;
				cmd.mem_re = 1'b1;
			end
			S_C_LDB: begin
				cmd.ld     = bgjc_pkg::LD_B;
				cmd.mul_go = 1'b1;
			end
			S_C_MUL: cmd.rnd_go = 1'b1;
			S_C_RND: cmd.sub_go = 1'b1;
			S_C_WR: begin
				mem_row    = k_row;
				mem_col    = l_q;
				cmd.mem_we = 1'b1;
				cmd.wsel   = bgjc_pkg::WS_SUB;
			end
			S_C_NEXT: ;
			S_FINISH: begin
				cmd.out_load   = !out_busy;
				cmd.out_zero   = 1'b1;
				cmd.out_status = zero_q ? bgjc_pkg::ST_ZERO : bgjc_pkg::ST_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			k_q         <= '0;
			l_q         <= '0;
			zero_q      <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == bgjc_pkg::MODE_WRITE) begin
							if (ok && 32'(column_index) == COLUMNS) begin
								held_q[in_row] <= hold_row;
							end
						end else if (mode == bgjc_pkg::MODE_READ) begin
							rd_ok_q <= ok;
							state_q <= S_RD_WAIT;
						end else if (mode == bgjc_pkg::MODE_RUN) begin
							j_q     <= '0;
							zero_q  <= 1'b0;
							state_q <= S_J_CHECK;
						end
					end
				end
				S_RD_WAIT: if (!out_busy) state_q <= S_IDLE;
				S_J_CHECK: begin
					if (!jlt) begin
						state_q <= S_FINISH;
					end else if (held_q[j_row]) begin
						j_q <= j_q + JW'(1);
					end else begin
						state_q <= S_P_LOAD;
					end
				end
				S_P_LOAD: state_q <= S_P_TEST;
				S_P_TEST: begin
					if (stat.p_zero) begin
						zero_q  <= 1'b1;
						j_q     <= j_q + JW'(1);
						state_q <= S_J_CHECK;
					end else begin
						l_q     <= '0;
						state_q <= S_N_RD;
					end
				end
				S_N_RD:  state_q <= l_is_j ? S_N_NEXT : S_N_LDA;
				S_N_LDA: state_q <= S_N_DST;
				S_N_DST: state_q <= S_N_DIV;
				S_N_DIV: if (stat.div_done) state_q <= S_N_NEXT;
				S_N_NEXT: begin
					if (l_last) begin
						k_q     <= '0;
						state_q <= S_K_CHECK;
					end else begin
						l_q     <= l_next;
						state_q <= S_N_RD;
					end
				end
				S_K_CHECK: begin
					if (!klt) begin
						j_q     <= j_q + JW'(1);
						state_q <= S_J_CHECK;
					end else if (k_q == j_q) begin
						k_q <= k_q + JW'(1);
					end else begin
						state_q <= S_X_LOAD;
					end
				end
				S_X_LOAD: state_q <= S_X_TEST;
				S_X_TEST: begin
					if (stat.x_zero) begin
						k_q     <= k_q + JW'(1);
						state_q <= S_K_CHECK;
					end else begin
						l_q     <= '0;
						state_q <= S_C_RDA;
					end
				end
				S_C_RDA: state_q <= l_is_j ? S_C_NEXT : S_C_LDA;
				S_C_LDA: state_q <= S_C_LDB;
				S_C_LDB: state_q <= S_C_MUL;
				S_C_MUL: state_q <= S_C_RND;
				S_C_RND: state_q <= S_C_WR;
				S_C_WR:  state_q <= S_C_NEXT;
				S_C_NEXT: begin
					if (l_last) begin
						k_q     <= k_q + JW'(1);
						state_q <= S_K_CHECK;
					end else begin
						l_q     <= l_next;
						state_q <= S_C_RDA;
					end
				end
				S_FINISH: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/block_gauss_jordan_conditioner_top.sv =====
// Top level of the block Gauss-Jordan conditioner: configuration port and unit wiring.
//
//  channel  direction  handshake              beat contents
//  in       input      in_valid / in_stall    mode, row_index, column_index, entry_value, hold_row
//  out      output     out_valid / out_stall  read_value, status
//  cfg      input      APB psel/penable       local_rows_used at 0, columns_used at 4
//
// A write beat goes straight into the store; a read beat passes the registered store read, then the output register.
// A run walks the store with one shared port: each unheld row with a nonzero pivot is normalized
// through the 48-step divider, then each other row with a nonzero pivot-column entry is cancelled.
// Reset clears the held marks, the sequencer and the output valid; the store holds no reset.
// Input is stalled while a read or run is at work, or while a result waits under out_stall.
module block_gauss_jordan_conditioner_top #(
	parameter int LOCAL_ROWS = 8,
	parameter int COLUMNS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         row_index,
	input  logic [4:0]         column_index,
	input  logic signed [31:0] entry_value,
	input  logic               hold_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int RW = (LOCAL_ROWS > 1) ? $clog2(LOCAL_ROWS) : 1;
	localparam int CW = $clog2(COLUMNS + 1);

	logic [3:0] rows_q;
	logic [4:0] cols_q;

	bgjc_pkg::dp_cmd_t  cmd;
	bgjc_pkg::dp_stat_t stat;
	logic [RW-1:0]      mem_row;
	logic [CW-1:0]      mem_col;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {27'd0, cols_q} : {28'd0, rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd8;
			cols_q <= 5'd16;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				cols_q <= pwdata[4:0];
			end else begin
				rows_q <= pwdata[3:0];
			end
		end
	end

	bgjc_ctrl #(
		.LOCAL_ROWS(LOCAL_ROWS),
		.COLUMNS   (COLUMNS),
		.RW        (RW),
		.CW        (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.row_index   (row_index),
		.column_index(column_index),
		.hold_row    (hold_row),
		.cfg_rows    (rows_q),
		.cfg_cols    (cols_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.mem_row     (mem_row),
		.mem_col     (mem_col),
		.stat        (stat)
	);

	bgjc_datapath #(
		.RW(RW),
		.CW(CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mem_row    (mem_row),
		.mem_col    (mem_col),
		.entry_value(entry_value),
		.stat       (stat),
		.read_value (read_value),
		.status     (status)
	);

endmodule

// ===== tb/block_gauss_jordan_conditioner_top_tb.sv =====
// Testbench of the block Gauss-Jordan conditioner: directed table, then random traffic.
module block_gauss_jordan_conditioner_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NROWS = 8;
	localparam int NCOLS = 16;
	localparam int RHS_COL = 16;
	localparam logic [2:0] ADDR_ROWS = 3'd0;
	localparam logic [2:0] ADDR_COLS = 3'd4;
	localparam longint CYCLE_LIMIT = 64'd6000000;

	typedef struct {
		logic [1:0]         mode;
		logic [2:0]         row;
		logic [4:0]         col;
		logic signed [31:0] value;
		logic               hold;
		bit                 fixed;
		logic signed [31:0] want_value;
		logic [1:0]         want_status;
	} beat_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = bgjc_pkg::MODE_WRITE;
	logic [2:0]         row_index = '0;
	logic [4:0]         column_index = '0;
	logic signed [31:0] entry_value = '0;
	logic               hold_row = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	block_gauss_jordan_conditioner_top dut (.*);

	always #1 clk = ~clk;

	// Shadow of the block state.
	logic signed [31:0] mat [NROWS][NCOLS];
	logic signed [31:0] rhs [NROWS];
	bit                 held [NROWS];
	bit                 written [NROWS][NCOLS + 1];
	logic [3:0]         rows_cfg = 4'd8;
	logic [4:0]         cols_cfg = 5'd16;
	result_t            pending_results[$];
	int                 errors = 0;
	longint             cycles = 0;
	int                 idle_pct = 0;
	int                 stall_pct = 0;

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] q_divide(logic signed [31:0] a, logic signed [31:0] p);
		longint unsigned na, pa, q, r;
		bit neg;
		na = (a < 0 ? -longint'(a) : longint'(a)) << 16;
		pa = p < 0 ? -longint'(p) : longint'(p);
		q = na / pa;
		r = na % pa;
		neg = (a < 0) != (p < 0);
		if (2 * r >= pa) q++;
		if (neg) return (q >= 64'h80000000) ? 32'sh80000000 : -longint'(q);
		return (q > 64'h7fffffff) ? 32'sh7fffffff : q[31:0];
	endfunction

	function automatic logic signed [31:0] q_mul_sub(logic signed [31:0] e2, logic signed [31:0] x,
			logic signed [31:0] e1);
		longint prod, m;
		longint unsigned mag;
		prod = longint'(x) * longint'(e1);
		mag = prod < 0 ? -prod : prod;
		m = longint'((mag + 64'd32768) >> 16);
		if (prod < 0) m = -m;
		return sat32(longint'(e2) - m);
	endfunction

	function automatic logic [1:0] eliminate();
		int nr, nc;
		logic signed [31:0] p, x;
		bit zero_seen;
		nr = rows_cfg > NROWS ? NROWS : rows_cfg;
		nc = cols_cfg > NCOLS ? NCOLS : cols_cfg;
		zero_seen = 0;
		if (nr > nc) nr = nc;
		for (int j = 0; j < nr; j++) begin
			if (held[j]) continue;
			p = mat[j][j];
			if (p == 0) begin
				zero_seen = 1;
				continue;
			end
			for (int l = 0; l < nc; l++) mat[j][l] = q_divide(mat[j][l], p);
			mat[j][j] = bgjc_pkg::Q_ONE;
			rhs[j] = q_divide(rhs[j], p);
			for (int k = 0; k < nr; k++) begin
				if (k == j) continue;
				x = mat[k][j];
				if (x == 0) continue;
				for (int l = 0; l < nc; l++) mat[k][l] = q_mul_sub(mat[k][l], x, mat[j][l]);
				mat[k][j] = 0;
				rhs[k] = q_mul_sub(rhs[k], x, rhs[j]);
			end
		end
		return zero_seen ? bgjc_pkg::ST_ZERO : bgjc_pkg::ST_DONE;
	endfunction

	// Applies one accepted beat to the shadow and queues what it should return.
	function automatic void predict(beat_t b);
		result_t r;
		bit ok;
		ok = b.row < NROWS && b.col <= RHS_COL;
		case (b.mode)
			bgjc_pkg::MODE_WRITE: begin
				if (ok) begin
					written[b.row][b.col] = 1;
					if (b.col == RHS_COL) begin
						rhs[b.row] = b.value;
						held[b.row] = b.hold;
					end else begin
						mat[b.row][b.col] = b.value;
					end
				end
			end
			bgjc_pkg::MODE_RUN: begin
				r.value = 0;
				r.status = eliminate();
				pending_results.push_back(r);
			end
			bgjc_pkg::MODE_READ: begin
				r.value = 0;
				if (ok) r.value = b.col == RHS_COL ? rhs[b.row] : mat[b.row][b.col];
				r.status = bgjc_pkg::ST_READ;
				if (b.fixed && r.value !== b.want_value) begin
					$error("read_value: expected %0d, got %0d", b.want_value, r.value);
					errors++;
				end
				if (b.fixed && r.status !== b.want_status) begin
					$error("status: expected %0d, got %0d", b.want_status, r.status);
					errors++;
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				result_t e;
				e = pending_results.pop_front();
				if (read_value !== e.value) begin
					$error("read_value: expected %0d, got %0d", e.value, read_value);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Valid stays high after the beat is taken; the next beat replaces it, and an idle gap or drain() lowers it.
	task automatic send_beat(beat_t b);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= b.mode;
		row_index <= b.row;
		column_index <= b.col;
		entry_value <= b.value;
		hold_row <= b.hold;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict(b);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ROWS) rows_cfg = data[3:0];
		else cols_cfg = data[4:0];
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic beat_t mk(logic [1:0] m, int r, int c, logic signed [31:0] v, bit h);
		beat_t b;
		b.mode = m;
		b.row = r;
		b.col = c;
		b.value = v;
		b.hold = h;
		b.fixed = 0;
		b.want_value = 0;
		b.want_status = bgjc_pkg::ST_READ;
		return b;
	endfunction

	function automatic logic signed [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 0;
			2: return $signed($urandom_range(131072)) - 65536;
			3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	// Fills every entry that a run or read may touch, with a random hold pattern.
	task automatic load_block(int diag_zero_pct);
		for (int r = 0; r < NROWS; r++) begin
			for (int c = 0; c < NCOLS; c++) begin
				logic signed [31:0] v;
				v = rand_entry();
				if (r == c && $urandom_range(99) >= diag_zero_pct && v == 0) v = bgjc_pkg::Q_ONE;
				if (r == c && $urandom_range(99) < diag_zero_pct) v = 0;
				send_beat(mk(bgjc_pkg::MODE_WRITE, r, c, v, $urandom_range(1)));
			end
			send_beat(mk(bgjc_pkg::MODE_WRITE, r, RHS_COL, rand_entry(), $urandom_range(3) == 0));
		end
	endtask

	task automatic random_beat();
		int r, c;
		r = $urandom_range(NROWS - 1);
		c = $urandom_range(RHS_COL);
		case ($urandom_range(9))
			0: send_beat(mk(bgjc_pkg::MODE_RUN, $urandom, $urandom, $urandom, $urandom));
			1: send_beat(mk(2'd3, $urandom, $urandom, $urandom, $urandom));
			2: send_beat(mk(bgjc_pkg::MODE_READ, r, $urandom_range(31), $urandom, $urandom));
			3, 4, 5: send_beat(mk(bgjc_pkg::MODE_WRITE, r, $urandom_range(31), rand_entry(),
				$urandom));
			default: begin
				if (written[r][c]) send_beat(mk(bgjc_pkg::MODE_READ, r, c, $urandom, $urandom));
				else send_beat(mk(bgjc_pkg::MODE_WRITE, r, c, rand_entry(), $urandom));
			end
		endcase
	endtask

	beat_t directed[$];

	initial begin
		beat_t b;
		for (int r = 0; r < NROWS; r++) begin
			held[r] = 0;
			for (int c = 0; c <= RHS_COL; c++) written[r][c] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a 2x2 system, extremes, out-of-range columns, unused mode, zero pivot.
		cfg_write(ADDR_ROWS, 32'd2);
		cfg_write(ADDR_COLS, 32'd2);
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 0, 0, 32'sh0002_0000, 1));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 0, 1, 32'sh7fffffff, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 1, 0, 32'sh80000000, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 1, 1, 32'sh0001_0000, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 0, RHS_COL, 32'sh0004_0000, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 1, RHS_COL, -32'sd1, 1));
		b = mk(bgjc_pkg::MODE_READ, 0, 1, 0, 0);
		b.fixed = 1;
		b.want_value = 32'sh7fffffff;
		directed.push_back(b);
		b = mk(bgjc_pkg::MODE_READ, 1, 0, 0, 0);
		b.fixed = 1;
		b.want_value = 32'sh80000000;
		directed.push_back(b);
		b = mk(bgjc_pkg::MODE_READ, 7, 31, 0, 1);
		b.fixed = 1;
		directed.push_back(b);
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 7, 17, 32'sh1234, 1));
		directed.push_back(mk(2'd3, 7, 31, -32'sd1, 1));
		directed.push_back(mk(bgjc_pkg::MODE_RUN, 0, 0, 0, 0));
		for (int r = 0; r < 2; r++)
			for (int c = 0; c <= 2; c++)
				directed.push_back(mk(bgjc_pkg::MODE_READ, r, c == 2 ? RHS_COL : c, 0, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 0, RHS_COL, 32'sd5, 0));
		directed.push_back(mk(bgjc_pkg::MODE_WRITE, 0, 0, 32'sd0, 0));
		directed.push_back(mk(bgjc_pkg::MODE_RUN, 0, 0, 0, 0));
		directed.push_back(mk(bgjc_pkg::MODE_READ, 1, RHS_COL, 0, 0));
		foreach (directed[i]) send_beat(directed[i]);
		drain();

		// A zero row count makes a run a no-op.
		cfg_write(ADDR_ROWS, 32'd0);
		send_beat(mk(bgjc_pkg::MODE_RUN, 0, 0, 0, 0));
		drain();
		cfg_write(ADDR_ROWS, 32'd15);
		cfg_write(ADDR_COLS, 32'd31);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = phase == 1 || phase == 3 ? (phase == 3 ? 32 : 79) : 0;
			stall_pct = phase == 2 || phase == 3 ? (phase == 3 ? 32 : 79) : 0;
			case (phase)
				0: begin cfg_write(ADDR_ROWS, 32'd8); cfg_write(ADDR_COLS, 32'd16); end
				1: begin cfg_write(ADDR_ROWS, 32'd1); cfg_write(ADDR_COLS, 32'd1); end
				2: begin
					cfg_write(ADDR_ROWS, $urandom_range(1, 15));
					cfg_write(ADDR_COLS, $urandom_range(1, 31));
				end
				default: begin cfg_write(ADDR_ROWS, 32'd4); cfg_write(ADDR_COLS, 32'd6); end
			endcase
			// The store keeps its contents between phases, so only two phases reload it.
			if (phase == 0 || phase == 2) load_block(phase == 2 ? 30 : 5);
			send_beat(mk(bgjc_pkg::MODE_RUN, $urandom, $urandom, $urandom, $urandom));
			for (int i = 0; i < 30; i++) random_beat();
			send_beat(mk(bgjc_pkg::MODE_RUN, 0, 0, 0, 0));
			for (int r = 0; r < NROWS; r++)
				send_beat(mk(bgjc_pkg::MODE_READ, r, $urandom_range(NCOLS - 1), 0, 0));
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		drain();
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
